>>> rtl/assert_macros.svh
// Assertion helpers. Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold whenever antecedent holds
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, expr, msg)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/twd_pkg.sv
`timescale 1ns / 1ps

package twd_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int LETTER_W = 5;

   typedef struct packed {
      logic [1:0]          operation;
      logic [LETTER_W-1:0] letter;
      logic                letter_valid;
      logic                last_letter;
   } req_type;

   typedef struct packed {
      logic [1:0] done_operation;
      logic       word_found;
      logic       pool_overflow;
   } rsp_type;

   // memory strobes from the controller to the two tables
   typedef struct packed {
      logic link_rd_en;
      logic link_wr_en;
      logic mark_rd_en;
      logic mark_wr_en;
      logic mark_wr_data;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_MARK,
      ST_RESP
   } state_type;

endpackage

>>> rtl/twd_ram.sv
`timescale 1ns / 1ps

module twd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/twd_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twd_ctrl
   import twd_pkg::*;
#(
   parameter int NODE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 26,
   localparam int NODE_W       = $clog2(NODE_COUNT),
   localparam int SLOT_W       = $clog2(NODE_COUNT * ALPHABET_SIZE)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   output mem_ctl_type       mem_ctl,
   output logic [SLOT_W-1:0] link_rd_addr,
   output logic [SLOT_W-1:0] link_wr_addr,
   output logic [NODE_W-1:0] link_wr_data,
   input  logic [NODE_W-1:0] link_rd_data,
   output logic [NODE_W-1:0] mark_addr,
   input  logic              mark_rd_data
);

   localparam int LINK_TOTAL = NODE_COUNT * ALPHABET_SIZE;
   localparam int FREE_W     = $clog2(NODE_COUNT + 1);
   localparam int SYM_W      = $clog2(ALPHABET_SIZE);
   localparam int CMP_W      = 9;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic              missing_ff, missing_in;
   logic              failed_ff, failed_in;
   logic [1:0]        op_ff, op_in;
   logic              last_ff, last_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              op_ok;
   logic              rsp_free;
   logic              pool_full;
   logic              clear_last;
   logic [SYM_W-1:0]  sym;
   logic [NODE_W-1:0] alloc_node;
   logic              found;

   assign accept     = req_valid && req_ready;
   assign op_ok      = req_data.operation != OP_UNUSED;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign pool_full  = free_ff >= FREE_W'(NODE_COUNT);
   assign clear_last = clr_ff == SLOT_W'(LINK_TOTAL - 1);
   assign alloc_node = NODE_W'(free_ff);

   // letter codes past the alphabet saturate to its last symbol
   always_comb begin
      if (CMP_W'(req_data.letter) >= CMP_W'(ALPHABET_SIZE)) begin
         sym = SYM_W'(ALPHABET_SIZE - 1);
      end else begin
         sym = SYM_W'(req_data.letter);
      end
   end

   assign slot_in = SLOT_W'(SLOT_W'(cursor_ff) * SLOT_W'(ALPHABET_SIZE)) + SLOT_W'(sym);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && op_ok) begin
               if (req_data.letter_valid) begin
                  state_in = ST_WALK;
               end else if (req_data.last_letter) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_WALK: begin
            state_in = last_ff ? ST_MARK : ST_IDLE;
         end
         ST_MARK: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: handshake and memory strobes
   always_comb begin
      req_ready    = 1'b0;
      mem_ctl      = '0;
      link_rd_addr = slot_in;
      link_wr_addr = slot_ff;
      link_wr_data = alloc_node;
      mark_addr    = cursor_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_ctl.link_wr_en = 1'b1;
            link_wr_addr       = clr_ff;
            link_wr_data       = '0;
            mem_ctl.mark_wr_en = clr_ff < SLOT_W'(NODE_COUNT);
            mark_addr          = NODE_W'(clr_ff);
         end
         ST_IDLE: begin
            req_ready          = 1'b1;
            mem_ctl.link_rd_en = req_valid && op_ok && req_data.letter_valid;
         end
         ST_WALK: begin
            mem_ctl.link_wr_en = (op_ff == OP_INSERT) && !failed_ff
                                 && (link_rd_data == '0) && !pool_full;
         end
         ST_MARK: begin
            case (op_ff)
               OP_INSERT: begin
                  mem_ctl.mark_wr_en   = !failed_ff;
                  mem_ctl.mark_wr_data = 1'b1;
               end
               OP_SEARCH: begin
                  mem_ctl.mark_rd_en = 1'b1;
               end
               OP_DELETE: begin
                  mem_ctl.mark_wr_en = !missing_ff;
               end
               default: begin
                  mem_ctl.mark_rd_en = 1'b0;
               end
            endcase
         end
         ST_RESP: begin
            req_ready = 1'b0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_INSERT: found = !failed_ff && !missing_ff;
         OP_SEARCH: found = !missing_ff && mark_rd_data;
         OP_DELETE: found = !missing_ff;
         default:   found = 1'b0;
      endcase
   end

   // register next values
   always_comb begin
      clr_in       = clr_ff;
      cursor_in    = cursor_ff;
      free_in      = free_ff;
      missing_in   = missing_ff;
      failed_in    = failed_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SLOT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_data.operation;
               last_in = req_data.last_letter;
            end
         end
         ST_WALK: begin
            if (op_ff == OP_INSERT) begin
               if (!failed_ff) begin
                  if (link_rd_data != '0) begin
                     cursor_in = link_rd_data;
                  end else if (pool_full) begin
                     failed_in = 1'b1;
                  end else begin
                     cursor_in  = alloc_node;
                     free_in    = free_ff + FREE_W'(1);
                     missing_in = 1'b1;
                  end
               end
            end else if (!missing_ff) begin
               if (link_rd_data == '0) begin
                  missing_in = 1'b1;
               end else begin
                  cursor_in = link_rd_data;
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.done_operation  = op_ff;
               rsp_data_in.word_found      = found;
               rsp_data_in.pool_overflow   = (op_ff == OP_INSERT) && failed_ff;
               cursor_in                   = '0;
               missing_in                  = 1'b0;
               failed_in                   = 1'b0;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         free_ff      <= FREE_W'(1);
         missing_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         free_ff      <= free_in;
         missing_ff   <= missing_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      last_ff     <= last_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_HOLDS(a_cursor_allocated, clock, reset, FREE_W'(cursor_ff) < free_ff, "cursor beyond allocated nodes")
   `ASSERT_HOLDS(a_pool_bound, clock, reset, free_ff <= FREE_W'(NODE_COUNT), "free pointer past pool")
   `ASSERT_IMPLIES(a_alloc_insert, clock, reset, (state_ff == ST_WALK) && mem_ctl.link_wr_en, (op_ff == OP_INSERT) && !failed_ff && (link_wr_data != '0), "bad link allocation")
   `ASSERT_IMPLIES(a_rsp_from_resp, clock, reset, rsp_valid_in && !rsp_valid_ff, state_ff == ST_RESP, "response raised outside completion")

endmodule

>>> rtl/trie_word_dictionary_top.sv
`timescale 1ns / 1ps

// Word dictionary held as a prefix trie: one request per letter, each naming
// insert, search or delete; the request carrying the last letter yields one
// response. After reset the block sweeps the child-link and end-mark tables to
// zero, one entry a cycle, before req_ready first rises. Each letter passes
// IDLE, where the child link is read from the link table, and then WALK, where
// the cursor is updated from the returned data. After the last letter the
// end-of-word table is accessed in MARK and the response is loaded in RESP; an
// empty-word request goes from IDLE straight to MARK. Requests are taken
// while an earlier response still waits in the output register; the response
// stage waits only when that register is full. Unused operation code 3 is
// accepted and dropped.
module trie_word_dictionary_top
   import twd_pkg::*;
#(
   parameter int NODE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int LINK_TOTAL = NODE_COUNT * ALPHABET_SIZE;
   localparam int SLOT_W     = $clog2(LINK_TOTAL);

   mem_ctl_type       mem_ctl;
   logic [SLOT_W-1:0] link_rd_addr;
   logic [SLOT_W-1:0] link_wr_addr;
   logic [NODE_W-1:0] link_wr_data;
   logic [NODE_W-1:0] link_rd_data;
   logic [NODE_W-1:0] mark_addr;
   logic              mark_rd_data;

   twd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (LINK_TOTAL)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (mem_ctl.link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   twd_ram #(
      .WIDTH (1),
      .DEPTH (NODE_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.mark_wr_en),
      .wr_addr (mark_addr),
      .wr_data (mem_ctl.mark_wr_data),
      .rd_en   (mem_ctl.mark_rd_en),
      .rd_addr (mark_addr),
      .rd_data (mark_rd_data)
   );

   twd_ctrl #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .mem_ctl      (mem_ctl),
      .link_rd_addr (link_rd_addr),
      .link_wr_addr (link_wr_addr),
      .link_wr_data (link_wr_data),
      .link_rd_data (link_rd_data),
      .mark_addr    (mark_addr),
      .mark_rd_data (mark_rd_data)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import twd_pkg::*;

   localparam int NODES      = 1024;
   localparam int SYMS       = 26;
   localparam int MAX_LEN    = 8;
   localparam int STALL_MAX  = 150000;  // stall limit, set to span the clearing sweep after reset
   localparam int HOLD_SPAN  = 300;

   typedef struct packed {
      logic [3:0]           len;
      logic [5*MAX_LEN-1:0] syms;
   } word_type;

   // Mirror of the trie: node table, end marks and the walk state of the word in flight.
   class trie_mirror;
      logic [9:0]  kid [NODES*SYMS];
      bit          end_mark [NODES];
      int unsigned fresh_node;
      int unsigned cursor;
      bit          strayed;
      bit          starved;
      rsp_type     replies_due[$];
      int          mismatches;

      function new();
         foreach (kid[i]) kid[i] = '0;
         foreach (end_mark[i]) end_mark[i] = 1'b0;
         fresh_node = 1;
         cursor     = 0;
         strayed    = 1'b0;
         starved    = 1'b0;
         mismatches = 0;
      endfunction

      function void note_request(req_type r);
         int unsigned sym;
         int unsigned slot;
         rsp_type     want;
         if (r.operation == OP_UNUSED) return;
         sym = 32'(r.letter);
         if (sym >= SYMS) sym = SYMS - 1;
         if (r.letter_valid) begin
            slot = cursor * SYMS + sym;
            if (r.operation == OP_INSERT) begin
               if (!starved) begin
                  if (kid[slot] == '0) begin
                     if (fresh_node >= NODES) begin
                        starved = 1'b1;
                     end else begin
                        kid[slot] = 10'(fresh_node);
                        end_mark[fresh_node] = 1'b0;
                        fresh_node++;
                        strayed = 1'b1;
                     end
                  end
                  if (!starved) cursor = 32'(kid[slot]);
               end
            end else if (!strayed) begin
               if (kid[slot] == '0) strayed = 1'b1;
               else cursor = 32'(kid[slot]);
            end
         end
         if (!r.last_letter) return;
         want.done_operation = r.operation;
         want.word_found     = 1'b0;
         want.pool_overflow  = 1'b0;
         case (r.operation)
            OP_INSERT: begin
               if (starved) begin
                  want.pool_overflow = 1'b1;
               end else begin
                  end_mark[cursor] = 1'b1;
                  want.word_found = !strayed;
               end
            end
            OP_SEARCH: want.word_found = !strayed && end_mark[cursor];
            default: begin
               if (!strayed) begin
                  end_mark[cursor] = 1'b0;
                  want.word_found = 1'b1;
               end
            end
         endcase
         replies_due.push_back(want);
         cursor  = 0;
         strayed = 1'b0;
         starved = 1'b0;
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: response with none expected, got op %0d found %0d overflow %0d",
                     $time, got.done_operation, got.word_found, got.pool_overflow);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         if (got !== want) begin
            $display("%0t: expected op %0d found %0d overflow %0d, got op %0d found %0d overflow %0d",
                     $time, want.done_operation, want.word_found, want.pool_overflow,
                     got.done_operation, got.word_found, got.pool_overflow);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   trie_mirror sb = new();
   bit         idle_on = 1'b1;
   int         letters_sent = 0;
   int         stalled_cycles = 0;
   word_type   known[$];

   trie_word_dictionary_top #(
      .NODE_COUNT    (NODES),
      .ALPHABET_SIZE (SYMS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_reply(rsp_data);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // response side: random back-pressure, plus one long hold-off so the block backs up
   initial begin
      bit held_off;
      held_off = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held_off && letters_sent >= 300) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_SPAN) @(posedge clock);
         end
         rsp_ready <= !(idle_on && $urandom_range(99) < 33);
      end
   end

   function automatic req_type item(input logic [1:0] op, input int sym,
                                    input bit has_letter, input bit last);
      req_type r;
      r.operation    = op;
      r.letter       = 5'(sym);
      r.letter_valid = has_letter;
      r.last_letter  = last;
      return r;
   endfunction

   function automatic word_type word_of(input int n, input int a = 0, input int b = 0,
                                        input int c = 0);
      word_type w;
      w.len  = 4'(n);
      w.syms = '0;
      w.syms[4:0]   = 5'(a);
      w.syms[9:5]   = 5'(b);
      w.syms[14:10] = 5'(c);
      return w;
   endfunction

   function automatic word_type random_word(input int min_len, input int max_len);
      word_type w;
      w.len  = 4'($urandom_range(max_len, min_len));
      w.syms = '0;
      for (int i = 0; i < MAX_LEN; i++) begin
         if ($urandom_range(19) == 0) w.syms[5*i +: 5] = 5'($urandom_range(31, 26));
         else w.syms[5*i +: 5] = 5'($urandom_range(25));
      end
      return w;
   endfunction

   function automatic word_type pick_known();
      word_type w;
      w = known[$urandom_range(known.size() - 1)];
      if ($urandom_range(3) == 0) w.len = 4'($urandom_range(w.len));
      return w;
   endfunction

   task automatic offer(input req_type r);
      while (idle_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (r.operation != OP_UNUSED) letters_sent++;
   endtask

   // mixed: each letter takes a random operation; noisy: stray unused-code requests in between
   task automatic send_word(input logic [1:0] op, input word_type w, input bit mixed,
                            input bit noisy);
      logic [1:0] this_op;
      if (w.len == 0) begin
         offer(item(op, $urandom_range(31), 1'b0, 1'b1));
         return;
      end
      for (int i = 0; i < w.len; i++) begin
         if (noisy && $urandom_range(99) < 3)
            offer(item(OP_UNUSED, $urandom_range(31), 1'($urandom_range(1)),
                       1'($urandom_range(1))));
         this_op = mixed ? 2'($urandom_range(2)) : op;
         offer(item(this_op, int'(w.syms[5*i +: 5]), 1'b1, i == w.len - 1));
      end
   endtask

   initial begin
      word_type   w;
      int         pick;
      logic [1:0] op;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // root as the empty word
      send_word(OP_SEARCH, word_of(0), 0, 0);
      send_word(OP_INSERT, word_of(0), 0, 0);
      send_word(OP_SEARCH, word_of(0), 0, 0);
      send_word(OP_DELETE, word_of(0), 0, 0);
      send_word(OP_INSERT, word_of(1, 0), 0, 0);
      send_word(OP_INSERT, word_of(1, 0), 0, 0);
      send_word(OP_SEARCH, word_of(2, 0, 25), 0, 0);
      send_word(OP_INSERT, word_of(1, 25), 0, 0);
      send_word(OP_SEARCH, word_of(1, 31), 0, 0);      // out-of-range code folds onto z
      send_word(OP_DELETE, word_of(2, 25, 25), 0, 0);
      send_word(OP_DELETE, word_of(1, 0), 0, 0);
      send_word(OP_SEARCH, word_of(1, 0), 0, 0);
      // operations mixed within one word
      offer(item(OP_INSERT, 1, 1'b1, 1'b0));
      offer(item(OP_SEARCH, 2, 1'b1, 1'b1));
      offer(item(OP_INSERT, 1, 1'b1, 1'b0));
      offer(item(OP_DELETE, 0, 1'b0, 1'b1));
      // unused code dropped mid-word
      offer(item(OP_INSERT, 3, 1'b1, 1'b0));
      offer(item(OP_UNUSED, 17, 1'b1, 1'b1));
      offer(item(OP_INSERT, 4, 1'b1, 1'b1));
      // letterless request that does not end the word
      offer(item(OP_SEARCH, 0, 1'b0, 1'b0));
      send_word(OP_SEARCH, word_of(2, 3, 4), 0, 0);

      while (letters_sent < 1520) begin
         idle_on = !(letters_sent >= 600 && letters_sent < 900);
         pick = $urandom_range(99);
         if (known.size() == 0 || pick < 50) begin
            if (known.size() == 0 || $urandom_range(99) < 85) begin
               w = random_word(2, MAX_LEN);
               if (known.size() < 256) known.push_back(w);
               else known[$urandom_range(255)] = w;
            end else begin
               w = pick_known();
            end
            send_word(OP_INSERT, w, 0, 1);
         end else if (pick < 72) begin
            send_word(OP_SEARCH, pick_known(), 0, 1);
         end else if (pick < 86) begin
            send_word(OP_DELETE, pick_known(), 0, 1);
         end else if (pick < 93) begin
            op = $urandom_range(1) ? OP_SEARCH : OP_DELETE;
            send_word(op, random_word(1, MAX_LEN), 0, 1);
         end else begin
            op = 2'($urandom_range(2));
            case ($urandom_range(3))
               0: send_word(op, word_of(0), 0, 0);
               1: send_word(op, random_word(1, 5), 1, 1);
               2: offer(item(OP_UNUSED, $urandom_range(31), 1'($urandom_range(1)),
                             1'($urandom_range(1))));
               default: offer(item(op, $urandom_range(31), 1'b0, 1'b0));
            endcase
         end
      end
      idle_on = 1'b1;

      req_valid <= 1'b0;
      // let the monitor note the last accepted request first
      @(posedge clock);
      while (sb.replies_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
